@@ src/swept_box_plane_trace_assert.svh @@
// Assertion macros used by the checker file.
`ifndef SWEPT_BOX_PLANE_TRACE_ASSERT_SVH
`define SWEPT_BOX_PLANE_TRACE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SBPT_ASSERT_NOW(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("sbpt assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SBPT_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("sbpt assertion failed");

`endif

@@ src/sbpt_pkg.sv @@
package sbpt_pkg;

    localparam int NORMAL_WIDTH    = 18;
    localparam int NORMAL_FRAC     = 16;
    localparam int CFG_INDEX_WIDTH = 3;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_POINT_X,
        REG_POINT_Y,
        REG_POINT_Z,
        REG_NORMAL_X,
        REG_NORMAL_Y,
        REG_NORMAL_Z
    } cfg_reg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } sbpt_qstat_t;

    // Width of the remainder and divisor words of the divider.
    function automatic int rem_width(int cw);
        return cw + 2 + NORMAL_WIDTH + 2 + 1;
    endfunction

    // Width of one queue word between the front and the back.
    function automatic int queue_width(int cw);
        return 1 + 6 * cw + 2 * rem_width(cw);
    endfunction

endpackage

@@ src/sbpt_intf.sv @@
interface sbpt_req_if #(parameter int COORD_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] start_x;
    logic signed [COORD_WIDTH-1:0] start_y;
    logic signed [COORD_WIDTH-1:0] start_z;
    logic signed [COORD_WIDTH-1:0] end_x;
    logic signed [COORD_WIDTH-1:0] end_y;
    logic signed [COORD_WIDTH-1:0] end_z;
    logic signed [COORD_WIDTH-1:0] box_min_x;
    logic signed [COORD_WIDTH-1:0] box_min_y;
    logic signed [COORD_WIDTH-1:0] box_min_z;
    logic signed [COORD_WIDTH-1:0] box_max_x;
    logic signed [COORD_WIDTH-1:0] box_max_y;
    logic signed [COORD_WIDTH-1:0] box_max_z;

    modport source (
        output valid, start_x, start_y, start_z, end_x, end_y, end_z,
               box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
        input  ready
    );
    modport sink (
        input  valid, start_x, start_y, start_z, end_x, end_y, end_z,
               box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
        output ready
    );
endinterface

interface sbpt_rsp_if #(parameter int COORD_WIDTH = 32, parameter int FRACTION_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic [FRACTION_BITS:0]        fraction;
    logic signed [COORD_WIDTH-1:0] stop_x;
    logic signed [COORD_WIDTH-1:0] stop_y;
    logic signed [COORD_WIDTH-1:0] stop_z;
    logic                          hit;

    modport source (output valid, fraction, stop_x, stop_y, stop_z, hit, input ready);
    modport sink (input valid, fraction, stop_x, stop_y, stop_z, hit, output ready);
endinterface

interface sbpt_cfg_if #(parameter int DATA_WIDTH = 32);
    import sbpt_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [CFG_INDEX_WIDTH-1:0] index;
    logic [DATA_WIDTH-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ src/sbpt_front.sv @@
module sbpt_front #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    sbpt_req_if.sink                                         req,
    sbpt_cfg_if.sink                                         cfg,
    input  sbpt_pkg::sbpt_qstat_t                            qstat,
    output logic                                             push,
    output logic [sbpt_pkg::queue_width(COORD_WIDTH)-1:0]    push_data
);
    import sbpt_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int DFW = CW + 2;
    localparam int PW  = DFW + NORMAL_WIDTH;
    localparam int DW  = PW + 2;
    localparam int RW  = rem_width(CW);
    localparam logic signed [RW-1:0] EPS = RW'(1) << NORMAL_FRAC;

    logic signed [CW-1:0]           point_reg [3];
    logic signed [NORMAL_WIDTH-1:0] normal_reg [3];

    logic                  adv;
    logic signed [CW-1:0]  s_in [3];
    logic signed [CW-1:0]  e_in [3];
    logic signed [CW-1:0]  ext_in [3];
    logic signed [DFW-1:0] sdiff_next [3];
    logic signed [DFW-1:0] ediff_next [3];

    logic                  v1_reg, v2_reg, v3_reg;
    logic signed [DFW-1:0] sdiff1_reg [3];
    logic signed [DFW-1:0] ediff1_reg [3];
    logic signed [CW-1:0]  start1_reg [3], end1_reg [3];
    logic signed [PW-1:0]  sprod2_reg [3], eprod2_reg [3];
    logic signed [CW-1:0]  start2_reg [3], end2_reg [3];
    logic signed [CW-1:0]  start3_reg [3], end3_reg [3];
    logic                  cross3_reg;
    logic [RW-1:0]         sdist3_reg, den3_reg;

    logic signed [DW-1:0]  sdist, edist;
    logic signed [RW-1:0]  dd;
    logic                  cross_next;
    logic [RW-1:0]         den_next;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                point_reg[i] <= '0;
            end
            normal_reg[0] <= '0;
            normal_reg[1] <= '0;
            normal_reg[2] <= NORMAL_WIDTH'(1) << NORMAL_FRAC;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_POINT_X:  point_reg[0]  <= cfg.data[CW-1:0];
                REG_POINT_Y:  point_reg[1]  <= cfg.data[CW-1:0];
                REG_POINT_Z:  point_reg[2]  <= cfg.data[CW-1:0];
                REG_NORMAL_X: normal_reg[0] <= cfg.data[NORMAL_WIDTH-1:0];
                REG_NORMAL_Y: normal_reg[1] <= cfg.data[NORMAL_WIDTH-1:0];
                REG_NORMAL_Z: normal_reg[2] <= cfg.data[NORMAL_WIDTH-1:0];
                default:      ;
            endcase
        end
    end

    assign adv       = !v3_reg || !qstat.full;
    assign req.ready = adv;
    assign push      = v3_reg && !qstat.full;

    assign s_in = '{req.start_x, req.start_y, req.start_z};
    assign e_in = '{req.end_x, req.end_y, req.end_z};

    // The corner facing the plane is the max corner where the normal is not positive.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ext_in[i] = 0;
        end
        ext_in[0] = (normal_reg[0][NORMAL_WIDTH-1] || normal_reg[0] == '0) ?
                    req.box_max_x : req.box_min_x;
        ext_in[1] = (normal_reg[1][NORMAL_WIDTH-1] || normal_reg[1] == '0) ?
                    req.box_max_y : req.box_min_y;
        ext_in[2] = (normal_reg[2][NORMAL_WIDTH-1] || normal_reg[2] == '0) ?
                    req.box_max_z : req.box_min_z;
        for (int i = 0; i < 3; i++)
        begin
            sdiff_next[i] = DFW'(s_in[i]) + DFW'(ext_in[i]) - DFW'(point_reg[i]);
            ediff_next[i] = DFW'(e_in[i]) + DFW'(ext_in[i]) - DFW'(point_reg[i]);
        end
    end

    always_comb
    begin
        sdist = DW'(sprod2_reg[0]) + DW'(sprod2_reg[1]) + DW'(sprod2_reg[2]);
        edist = DW'(eprod2_reg[0]) + DW'(eprod2_reg[1]) + DW'(eprod2_reg[2]);
        cross_next = !sdist[DW-1] && edist[DW-1];
        dd = RW'(sdist) - RW'(edist);
        den_next = (dd < EPS) ? EPS : dd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= req.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sdiff1_reg[i] <= sdiff_next[i];
                ediff1_reg[i] <= ediff_next[i];
                start1_reg[i] <= s_in[i];
                end1_reg[i]   <= e_in[i];
                sprod2_reg[i] <= PW'(sdiff1_reg[i]) * PW'(normal_reg[i]);
                eprod2_reg[i] <= PW'(ediff1_reg[i]) * PW'(normal_reg[i]);
                start2_reg[i] <= start1_reg[i];
                end2_reg[i]   <= end1_reg[i];
                start3_reg[i] <= start2_reg[i];
                end3_reg[i]   <= end2_reg[i];
            end
            cross3_reg <= cross_next;
            sdist3_reg <= RW'(sdist);
            den3_reg   <= den_next;
        end
    end

    assign push_data = {cross3_reg, start3_reg[0], start3_reg[1], start3_reg[2],
                        end3_reg[0], end3_reg[1], end3_reg[2], sdist3_reg, den3_reg};

endmodule

@@ src/sbpt_queue.sv @@
module sbpt_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [WIDTH-1:0]      push_data,
    input  logic                  pop,
    output logic [WIDTH-1:0]      pop_data,
    output sbpt_pkg::sbpt_qstat_t qstat
);
    import sbpt_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNW-1:0]   count_reg;

    assign qstat.full  = (count_reg == CNW'(DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign pop_data    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ src/sbpt_back.sv @@
module sbpt_back #(
    parameter int COORD_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  sbpt_pkg::sbpt_qstat_t                         qstat,
    input  logic [sbpt_pkg::queue_width(COORD_WIDTH)-1:0] pop_data,
    output logic                                          pop,
    sbpt_rsp_if.source                                    rsp
);
    import sbpt_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int FB  = FRACTION_BITS;
    localparam int RW  = rem_width(CW);
    localparam int PRW = CW + FB + 3;
    localparam logic signed [PRW-1:0] HALF = PRW'(1) << (FB - 1);

    logic                 adv;
    logic                 q_cross;
    logic signed [CW-1:0] q_st [3];
    logic signed [CW-1:0] q_en [3];
    logic [RW-1:0]        q_rem, q_den;

    logic                 dv_reg [FB];
    logic                 dcross_reg [FB];
    logic [RW-1:0]        rem_reg [FB];
    logic [RW-1:0]        den_reg [FB];
    logic [FB-1:0]        quo_reg [FB];
    logic signed [CW-1:0] dst_reg [FB][3];
    logic signed [CW-1:0] den_pos_reg [FB][3];
    logic [RW-1:0]        rem_next [FB];
    logic [FB-1:0]        quo_next [FB];

    logic                  vm_reg, hm_reg;
    logic [FB:0]           fm_reg;
    logic signed [PRW-1:0] prod_reg [3];
    logic signed [CW-1:0]  stm_reg [3];
    logic [FB:0]           frac_next;
    logic signed [PRW-1:0] prod_next [3];

    logic                  vo_reg, hit_reg;
    logic [FB:0]           fraction_reg;
    logic signed [CW-1:0]  stop_reg [3];
    logic signed [CW-1:0]  stop_next [3];

    assign adv = !vo_reg || rsp.ready;
    assign pop = adv && !qstat.empty;

    always_comb
    begin
        {q_cross, q_st[0], q_st[1], q_st[2], q_en[0], q_en[1], q_en[2], q_rem, q_den} =
            pop_data;
    end

    // One restoring quotient bit per stage.
    always_comb
    begin
        logic [RW-1:0] r;
        logic [RW-1:0] d;
        logic [RW-1:0] r2;
        logic [FB-1:0] qq;
        for (int k = 0; k < FB; k++)
        begin
            if (k == 0)
            begin
                r  = q_rem;
                d  = q_den;
                qq = '0;
            end
            else
            begin
                r  = rem_reg[k-1];
                d  = den_reg[k-1];
                qq = quo_reg[k-1];
            end
            r2 = {r[RW-2:0], 1'b0};
            if (r2 >= d)
            begin
                rem_next[k] = r2 - d;
                quo_next[k] = {qq[FB-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = r2;
                quo_next[k] = {qq[FB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < FB; k++)
            begin
                dv_reg[k] <= 1'b0;
            end
            vm_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (adv)
        begin
            dv_reg[0] <= !qstat.empty;
            for (int k = 1; k < FB; k++)
            begin
                dv_reg[k] <= dv_reg[k-1];
            end
            vm_reg <= dv_reg[FB-1];
            vo_reg <= vm_reg;
        end
    end

    always_comb
    begin
        frac_next = dcross_reg[FB-1] ? {1'b0, quo_reg[FB-1]} : (FB + 1)'(1) << FB;
        for (int i = 0; i < 3; i++)
        begin
            prod_next[i] = PRW'((CW + 1)'(den_pos_reg[FB-1][i]) - (CW + 1)'(dst_reg[FB-1][i]))
                           * PRW'($signed({1'b0, frac_next}));
        end
    end

    always_comb
    begin
        logic signed [PRW-1:0] rounded;
        for (int i = 0; i < 3; i++)
        begin
            rounded      = (prod_reg[i] + HALF) >>> FB;
            stop_next[i] = stm_reg[i] + rounded[CW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0]    <= rem_next[0];
            den_reg[0]    <= q_den;
            quo_reg[0]    <= quo_next[0];
            dcross_reg[0] <= q_cross;
            dst_reg[0]    <= q_st;
            den_pos_reg[0] <= q_en;
            for (int k = 1; k < FB; k++)
            begin
                rem_reg[k]     <= rem_next[k];
                den_reg[k]     <= den_reg[k-1];
                quo_reg[k]     <= quo_next[k];
                dcross_reg[k]  <= dcross_reg[k-1];
                dst_reg[k]     <= dst_reg[k-1];
                den_pos_reg[k] <= den_pos_reg[k-1];
            end
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i] <= prod_next[i];
                stm_reg[i]  <= dst_reg[FB-1][i];
                stop_reg[i] <= stop_next[i];
            end
            fm_reg       <= frac_next;
            hm_reg       <= dcross_reg[FB-1];
            fraction_reg <= fm_reg;
            hit_reg      <= hm_reg;
        end
    end

    assign rsp.valid    = vo_reg;
    assign rsp.fraction = fraction_reg;
    assign rsp.stop_x   = stop_reg[0];
    assign rsp.stop_y   = stop_reg[1];
    assign rsp.stop_z   = stop_reg[2];
    assign rsp.hit      = hit_reg;

endmodule

@@ src/swept_box_plane_trace.sv @@
// Traces a swept box against one configured plane and returns the completed
// fraction, the stop position and a hit flag for every word. The block takes
// one word per cycle while the queue has room and returns results in order.
// Three front stages form the corner offsets, the distance products and their
// sums, the queue holds the word, the divider spends one stage per fraction
// bit, and two more stages scale the move and register the result. The
// pipelined divider sets the latency, and a four-word queue lets the front keep
// taking words while the output is held.
module swept_box_plane_trace #(
    parameter int COORD_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    sbpt_req_if.sink   req,
    sbpt_rsp_if.source rsp,
    sbpt_cfg_if.sink   cfg
);
    import sbpt_pkg::*;

    localparam int QW = queue_width(COORD_WIDTH);

    logic          push, pop;
    logic [QW-1:0] push_data, pop_data;
    sbpt_qstat_t   qstat;

    sbpt_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg       (cfg),
        .qstat     (qstat),
        .push      (push),
        .push_data (push_data)
    );

    sbpt_queue #(.WIDTH(QW), .DEPTH(4)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .qstat     (qstat)
    );

    sbpt_back #(.COORD_WIDTH(COORD_WIDTH), .FRACTION_BITS(FRACTION_BITS)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .qstat    (qstat),
        .pop_data (pop_data),
        .pop      (pop),
        .rsp      (rsp)
    );

endmodule

@@ src/sbpt_checker.sv @@
`include "swept_box_plane_trace_assert.svh"

module sbpt_checker #(
    parameter int COORD_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   rsp_valid,
    input logic                   rsp_ready,
    input logic [FRACTION_BITS:0] fraction,
    input logic [COORD_WIDTH-1:0] stop_x,
    input logic                   hit
);

    `SBPT_ASSERT_NEXT(a_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(stop_x) && $stable(fraction))
    `SBPT_ASSERT_NOW(a_hit_partial, clk, rst_n, rsp_valid && hit, !fraction[FRACTION_BITS])
    `SBPT_ASSERT_NOW(a_miss_full, clk, rst_n, rsp_valid && !hit, fraction == ((FRACTION_BITS + 1)'(1) << FRACTION_BITS))

endmodule

bind swept_box_plane_trace sbpt_checker #(
    .COORD_WIDTH   (COORD_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
) u_sbpt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .fraction  (rsp.fraction),
    .stop_x    (rsp.stop_x),
    .hit       (rsp.hit)
);
